### hdl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants of the nearest-neighbor scan
// widths of coordinates, distances and keys, register codes, cell types
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int CoordW   = 8;
  localparam int NumCoord = 4;
  localparam int IndexW   = 16;
  localparam int DistW    = 9;
  // largest sum of four squared differences is 260100
  localparam int SumW     = 18;
  localparam int KeyW     = DistW + IndexW;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUERY_X0 = CfgIdxW'(0),
    REG_QUERY_X1 = CfgIdxW'(1),
    REG_QUERY_X2 = CfgIdxW'(2),
    REG_QUERY_X3 = CfgIdxW'(3)
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [KeyW-1:0]          key_t;

  // one slot of the sorted list, key = {distance, index}
  typedef struct packed {
    logic valid;
    key_t key;
  } entry_t;

  // command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

endpackage

### hdl/knn_ifs.sv
// ----------------------------------------------------------------------------
// knn channel interfaces
// point input, result output and register write channels
// ----------------------------------------------------------------------------
interface knn_point_if import knn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IndexW-1:0]        point_index;
  logic signed [CoordW-1:0] point_x0;
  logic signed [CoordW-1:0] point_x1;
  logic signed [CoordW-1:0] point_x2;
  logic signed [CoordW-1:0] point_x3;
  logic                     final_point;

  modport source (
    output valid, point_index, point_x0, point_x1, point_x2, point_x3, final_point,
    input  ready
  );
  modport sink (
    input  valid, point_index, point_x0, point_x1, point_x2, point_x3, final_point,
    output ready
  );
endinterface

interface knn_result_if import knn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] neighbour_index;
  logic [DistW-1:0]  neighbour_distance;
  logic              final_result;

  modport source (
    output valid, neighbour_index, neighbour_distance, final_result,
    input  ready
  );
  modport sink (
    input  valid, neighbour_index, neighbour_distance, final_result,
    output ready
  );
endinterface

interface knn_cfg_if import knn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/knn_dist.sv
// ----------------------------------------------------------------------------
// knn_dist: squared euclidean distance
// four lane differences, squares and their sum, registered on start
// ----------------------------------------------------------------------------
module knn_dist import knn_pkg::*; (
  input  logic            clk_i,
  input  logic            start_i,
  input  coord_t          query_i [NumCoord],
  input  coord_t          coord_i [NumCoord],
  output logic [SumW-1:0] sum_o
);

  localparam int DiffW = CoordW + 1;
  localparam int SqW   = 2 * DiffW;

  logic signed [DiffW-1:0] diff [NumCoord];
  logic signed [SqW-1:0]   diff_ext [NumCoord];
  logic signed [SqW-1:0]   sq [NumCoord];
  logic [SumW-1:0]         sum_d;
  logic [SumW-1:0]         sum_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NumCoord; i++) begin
      diff[i]     = DiffW'(query_i[i]) - DiffW'(coord_i[i]);
      diff_ext[i] = SqW'(diff[i]);
      sq[i]       = diff_ext[i] * diff_ext[i];
      sum_d       = sum_d + SumW'(sq[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### hdl/knn_isqrt.sv
// ----------------------------------------------------------------------------
// knn_isqrt: iterative floor square root
// one result bit per cycle from the top down, done pulses after the last bit
// ----------------------------------------------------------------------------
module knn_isqrt import knn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  radicand_i,
  output logic             done_o,
  output logic [DistW-1:0] root_o
);

  localparam int SqW = 2 * DistW;

  logic             busy_q;
  logic             done_q;
  logic [SumW-1:0]  rad_q;
  logic [DistW-1:0] root_q;
  logic [DistW-1:0] root_d;
  logic [DistW-1:0] bit_q;
  logic [DistW-1:0] trial;
  logic [SqW-1:0]   trial_sq;

  always_comb begin
    trial    = root_q | bit_q;
    trial_sq = SqW'(trial) * SqW'(trial);
    root_d   = (trial_sq <= SqW'(rad_q)) ? trial : root_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      bit_q  <= {1'b1, {(DistW-1){1'b0}}};
    end else if (busy_q) begin
      root_q <= root_d;
      bit_q  <= bit_q >> 1;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hdl/knn_cell.sv
// ----------------------------------------------------------------------------
// knn_cell: one slot of the sorted neighbor list
// on insert takes the new key or its left neighbor, on drain its right one
// ----------------------------------------------------------------------------
module knn_cell import knn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  key_t       key_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  output entry_t     entry_o
);

  logic valid_q;
  key_t key_q;
  logic beats_own;
  logic beats_prev;

  // an empty slot ranks after everything
  assign beats_own  = !valid_q || (key_i < key_q);
  assign beats_prev = !prev_i.valid || (key_i < prev_i.key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift_out) begin
      valid_q <= next_i.valid;
    end else if (ctrl_i.insert && beats_own) begin
      valid_q <= beats_prev ? prev_i.valid : 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_out) begin
      key_q <= next_i.key;
    end else if (ctrl_i.insert && beats_own) begin
      key_q <= beats_prev ? prev_i.key : key_i;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q};

endmodule

### hdl/brute_force_knn_scan.sv
// ----------------------------------------------------------------------------
// brute_force_knn_scan: k-nearest-neighbor scan, euclidean, four dimensions
//
// cfg_i writes the query coordinates (index 0..3, other indexes ignored);
// writes are taken in every cycle; the user makes them only while the block
// is idle, which the block itself does not enforce. point_i carries one
// database point per transfer. its distance to the query is the floor square
// root of the summed squared differences. a chain of TOP_K cells keeps the
// closest (distance, index) pairs in ascending order, the smaller index first
// on equal distance. a new point is not taken until the last one is through:
// its squared sum is registered, the bit-serial square root unit works out its
// nine result bits and raises its done flag, then the point enters the chain.
// a point flagged final_point is scanned like any other; then the chain
// drains through result_o, one pair per cycle while the sink takes them,
// final_result on the last pair, leaving the chain empty.
// result_o comes from an output register: a stall on the sink holds the pair
// and the drain; point_i is ready again once the drain is done, even while
// the last pair still waits there.
// reset empties the chain and zeroes the query registers.
// ----------------------------------------------------------------------------
module brute_force_knn_scan import knn_pkg::*; #(
  parameter int TOP_K = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  knn_cfg_if.sink      cfg_i,
  knn_point_if.sink    point_i,
  knn_result_if.source result_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSum   = 3'd1;
  localparam logic [2:0] StRoot  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // query registers
  coord_t query_q [NumCoord];
  coord_t point_coord [NumCoord];

  // captured point fields while its distance is worked out
  logic [IndexW-1:0] index_q;
  logic              final_q;

  logic             point_xfer;
  logic [SumW-1:0]  sum;
  logic             root_done;
  logic [DistW-1:0] root;

  // sorted chain
  cell_ctrl_t cell_ctrl;
  key_t       new_key;
  entry_t     cells [TOP_K];
  entry_t     head;
  entry_t     tail;
  logic       last_pair;

  // output register
  logic              out_valid_q;
  logic              out_valid_d;
  logic [IndexW-1:0] out_index_q;
  logic [DistW-1:0]  out_dist_q;
  logic              out_final_q;
  logic              out_load;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoord; i++) begin
        query_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_QUERY_X0: query_q[0] <= cfg_i.data;
        REG_QUERY_X1: query_q[1] <= cfg_i.data;
        REG_QUERY_X2: query_q[2] <= cfg_i.data;
        REG_QUERY_X3: query_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- distance
  assign point_i.ready = (state_q == StIdle);
  assign point_xfer    = point_i.valid && point_i.ready;

  assign point_coord[0] = point_i.point_x0;
  assign point_coord[1] = point_i.point_x1;
  assign point_coord[2] = point_i.point_x2;
  assign point_coord[3] = point_i.point_x3;

  always_ff @(posedge clk_i) begin
    if (point_xfer) begin
      index_q <= point_i.point_index;
      final_q <= point_i.final_point;
    end
  end

  knn_dist u_dist (
    .clk_i   (clk_i),
    .start_i (point_xfer),
    .query_i (query_q),
    .coord_i (point_coord),
    .sum_o   (sum)
  );

  knn_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StSum),
    .radicand_i (sum),
    .done_o     (root_done),
    .root_o     (root)
  );

  // ---------------------------------------------------------------- chain
  // the head looks valid with the smallest key, so cell 0 never takes it
  assign head      = '{valid: 1'b1, key: '0};
  assign tail      = '{valid: 1'b0, key: '0};
  assign new_key   = {root, index_q};
  assign out_load  = (state_q == StDrain) && (!out_valid_q || result_o.ready);

  assign cell_ctrl = '{insert: (state_q == StRoot) && root_done, shift_out: out_load};

  for (genvar g = 0; g < TOP_K; g++) begin : g_cell
    entry_t prev;
    entry_t next;
    if (g == 0) begin : g_first
      assign prev = head;
    end else begin : g_mid
      assign prev = cells[g-1];
    end
    if (g == TOP_K - 1) begin : g_last
      assign next = tail;
    end else begin : g_inner
      assign next = cells[g+1];
    end

    knn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .key_i   (new_key),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (cells[g])
    );
  end

  // last pair of the drain when nothing follows the head cell
  if (TOP_K == 1) begin : g_one
    assign last_pair = 1'b1;
  end else begin : g_many
    assign last_pair = !cells[1].valid;
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (point_xfer) state_d = StSum;
      StSum:   state_d = StRoot;
      StRoot:  if (root_done) state_d = final_q ? StDrain : StIdle;
      StDrain: if (out_load && last_pair) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_d = out_valid_q && !result_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= cells[0].key[IndexW-1:0];
      out_dist_q  <= cells[0].key[KeyW-1:IndexW];
      out_final_q <= last_pair;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.neighbour_index    = out_index_q;
  assign result_o.neighbour_distance = out_dist_q;
  assign result_o.final_result       = out_final_q;

endmodule
